FILE: rtl/rssi_adaptive_frame_throttle_top_defines.svh
// Assertion macros for the RSSI frame throttle.
// Used by the top level only; each macro expands to one concurrent assertion.
`ifndef RSSI_ADAPTIVE_FRAME_THROTTLE_TOP_DEFINES_SVH
`define RSSI_ADAPTIVE_FRAME_THROTTLE_TOP_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define RAFT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define RAFT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define RAFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/raft_pkg.sv
// Shared types, constants and helper functions for the RSSI frame throttle.
// No dependencies; the top level refers to it by scoped names.
package raft_pkg;

  // Window store geometry and derived widths.
  localparam int MAX_WINDOW = 8;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int HEAD_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SLOT_W     = CNT_W + 1;
  localparam int SUM_W      = 8 + $clog2(MAX_WINDOW);
  localparam int ALU_W      = SUM_W + 1;
  localparam int BIT_W      = $clog2(SUM_W);

  // Frame counter wraps at this count.
  localparam int CTR_MOD = 24;
  localparam int CTR_W   = 5;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_WINDOW_LENGTH = 3'd0,
    REG_STOP_LEVEL    = 3'd1,
    REG_BAND_EIGHTH   = 3'd2,
    REG_BAND_SIXTH    = 3'd3,
    REG_BAND_QUARTER  = 3'd4,
    REG_BAND_HALF     = 3'd5,
    REG_CONFIGURED    = 3'd6
  } reg_index_t;

  // Configuration reset values.
  localparam logic [3:0]        RST_WINDOW_LENGTH = 4'd3;
  localparam logic signed [7:0] RST_STOP_LEVEL    = -8'sd80;
  localparam logic signed [7:0] RST_BAND_EIGHTH   = -8'sd70;
  localparam logic signed [7:0] RST_BAND_SIXTH    = -8'sd60;
  localparam logic signed [7:0] RST_BAND_QUARTER  = -8'sd50;
  localparam logic signed [7:0] RST_BAND_HALF     = -8'sd40;

  // Result codes.
  typedef enum logic [2:0] {
    VERDICT_SENT       = 3'd0,
    VERDICT_NO_STATION = 3'd1,
    VERDICT_TOO_WEAK   = 3'd2,
    VERDICT_SKIPPED    = 3'd3,
    VERDICT_UNCONFIG   = 3'd4
  } verdict_t;

  // Send periods by band.
  localparam logic [3:0] PERIOD_ONE     = 4'd1;
  localparam logic [3:0] PERIOD_TWO     = 4'd2;
  localparam logic [3:0] PERIOD_FOUR    = 4'd4;
  localparam logic [3:0] PERIOD_SIX     = 4'd6;
  localparam logic [3:0] PERIOD_EIGHT   = 4'd8;

  // Bit positions of the input flags in tuser.
  localparam int TUSER_MODE  = 0;
  localparam int TUSER_FOUND = 1;

  // Window length register clamped to the range of the store.
  function automatic logic [CNT_W-1:0] eff_length(input logic [3:0] wl);
    logic [CNT_W-1:0] l;
    if (wl == 4'd0) begin
      l = CNT_W'(1);
    end else if (int'(wl) > MAX_WINDOW) begin
      l = CNT_W'(MAX_WINDOW);
    end else begin
      l = CNT_W'(wl);
    end
    return l;
  endfunction

  // True when the counter value is a multiple of the period.
  function automatic logic phase_hit(input logic [CTR_W-1:0] c, input logic [3:0] p);
    logic hit;
    unique case (p)
      PERIOD_TWO:   hit = (c[0] == 1'b0);
      PERIOD_FOUR:  hit = (c[1:0] == 2'd0);
      PERIOD_EIGHT: hit = (c[2:0] == 3'd0);
      PERIOD_SIX:   hit = (c == 5'd0) || (c == 5'd6) || (c == 5'd12) || (c == 5'd18);
      default:      hit = 1'b1;
    endcase
    return hit;
  endfunction

endpackage

FILE: rtl/rssi_adaptive_frame_throttle_top.sv
// RSSI frame throttle: sliding-window average of link samples and a frame gate.
// Depends on raft_pkg and on rssi_adaptive_frame_throttle_top_defines.svh.
// A measurement beat runs eleven divide steps on the shared adder, none when the window is
// empty; a frame walks the threshold compares. One beat is in work at a time, the next
// accepted once the result is registered. Reset (rst_n low, synchronous) clears
// bookkeeping and loads register defaults.

`include "rssi_adaptive_frame_throttle_top_defines.svh"

module rssi_adaptive_frame_throttle_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input beats.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rssi_sample
  input  logic [1:0]  in_tuser,   // [0] mode, [1] sample_found
  // Result beats.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] send_frame, [3:1] verdict, [11:4] average_rssi, [12] have_average,
  // [16:13] send_period, [23:17] zero
  output logic [23:0] out_tdata,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int CNT_W  = raft_pkg::CNT_W;
  localparam int HEAD_W = raft_pkg::HEAD_W;
  localparam int SLOT_W = raft_pkg::SLOT_W;
  localparam int SUM_W  = raft_pkg::SUM_W;
  localparam int ALU_W  = raft_pkg::ALU_W;
  localparam int BIT_W  = raft_pkg::BIT_W;
  localparam int CTR_W  = raft_pkg::CTR_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PUSH, ST_ADD, ST_DROP, ST_MAG, ST_DIV, ST_SIGN, ST_CMP, ST_COUNT, ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    CMP_STOP, CMP_EIGHTH, CMP_SIXTH, CMP_QUARTER, CMP_HALF
  } cmp_step_t;

  state_t    state_r, state_nxt;
  cmp_step_t cmp_r, cmp_nxt;

  // Configuration registers.
  logic [3:0]        wlen_r;
  logic signed [7:0] stop_r, eighth_r, sixth_r, quarter_r, half_r;
  logic              configured_r;

  // Window bookkeeping and working registers.
  logic [7:0]              win_r [raft_pkg::MAX_WINDOW];
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [HEAD_W-1:0]       head_r, head_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [7:0]       avg_r, avg_nxt;
  logic [CTR_W-1:0]        ctr_r, ctr_nxt;
  logic signed [7:0]       sample_r, sample_nxt;
  logic [SUM_W-1:0]        dvd_r, dvd_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic [BIT_W-1:0]        bit_r, bit_nxt;
  raft_pkg::verdict_t      verdict_r, verdict_nxt;
  logic [3:0]              period_r, period_nxt;
  logic                    send_r, send_nxt;

  // Output register.
  logic                    out_valid_r, out_valid_nxt;
  logic                    o_send_r, o_send_nxt;
  raft_pkg::verdict_t      o_verdict_r, o_verdict_nxt;
  logic signed [7:0]       o_avg_r, o_avg_nxt;
  logic                    o_have_r, o_have_nxt;
  logic [3:0]              o_period_r, o_period_nxt;

  // Window write port.
  logic                    win_we;
  logic [HEAD_W-1:0]       win_waddr;
  logic [7:0]              win_rd;

  // Shared adder/subtractor.
  logic [ALU_W-1:0]        alu_a, alu_b, alu_res;
  logic                    alu_sub;

  logic [HEAD_W-1:0]       head_inc;
  logic [SLOT_W-1:0]       slot_sum;
  logic [HEAD_W-1:0]       wr_slot;
  logic [CNT_W-1:0]        eff_len;
  logic signed [7:0]       cmp_thr;
  logic                    alu_neg;
  logic [CNT_W:0]          div_shift;
  logic [CTR_W-1:0]        ctr_inc;

  assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
  assign alu_neg = alu_res[ALU_W-1];

  // Head advance and write slot, both modulo the store depth.
  assign head_inc = (int'(head_r) == raft_pkg::MAX_WINDOW - 1) ? '0 : head_r + HEAD_W'(1);
  assign slot_sum = SLOT_W'(head_r) + SLOT_W'(count_r);
  assign wr_slot  = (slot_sum >= SLOT_W'(raft_pkg::MAX_WINDOW))
                    ? HEAD_W'(slot_sum - SLOT_W'(raft_pkg::MAX_WINDOW))
                    : HEAD_W'(slot_sum);
  assign win_rd   = win_r[head_r];
  assign eff_len  = raft_pkg::eff_length(wlen_r);

  assign div_shift = {rem_r, dvd_r[SUM_W-1]};
  assign ctr_inc   = (int'(ctr_r) == raft_pkg::CTR_MOD - 1) ? '0 : ctr_r + CTR_W'(1);

  // Threshold for the current compare step.
  always_comb begin
    unique case (cmp_r)
      CMP_STOP:    cmp_thr = stop_r;
      CMP_EIGHTH:  cmp_thr = eighth_r;
      CMP_SIXTH:   cmp_thr = sixth_r;
      CMP_QUARTER: cmp_thr = quarter_r;
      default:     cmp_thr = half_r;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    cmp_nxt       = cmp_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    sum_nxt       = sum_r;
    avg_nxt       = avg_r;
    ctr_nxt       = ctr_r;
    sample_nxt    = sample_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    verdict_nxt   = verdict_r;
    period_nxt    = period_r;
    send_nxt      = send_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    o_send_nxt    = o_send_r;
    o_verdict_nxt = o_verdict_r;
    o_avg_nxt     = o_avg_r;
    o_have_nxt    = o_have_r;
    o_period_nxt  = o_period_r;
    win_we        = 1'b0;
    win_waddr     = head_r;
    alu_a         = '0;
    alu_b         = '0;
    alu_sub       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          sample_nxt = $signed(in_tdata);
          period_nxt = raft_pkg::PERIOD_ONE;
          send_nxt   = 1'b0;
          if (!in_tuser[raft_pkg::TUSER_MODE]) begin
            verdict_nxt = raft_pkg::VERDICT_UNCONFIG;
            state_nxt   = in_tuser[raft_pkg::TUSER_FOUND] ? ST_PUSH : ST_MAG;
          end else if (count_r == '0) begin
            verdict_nxt = raft_pkg::VERDICT_NO_STATION;
            state_nxt   = ST_FIN;
          end else begin
            cmp_nxt   = CMP_STOP;
            state_nxt = ST_CMP;
          end
        end
      end

      // Store the sample; a full store first gives up its oldest entry.
      ST_PUSH: begin
        win_we = 1'b1;
        alu_a  = ALU_W'(sum_r);
        if (int'(count_r) == raft_pkg::MAX_WINDOW) begin
          win_waddr = head_r;
          alu_b     = ALU_W'($signed(win_rd));
          alu_sub   = 1'b1;
          sum_nxt   = $signed(alu_res[SUM_W-1:0]);
          head_nxt  = head_inc;
          state_nxt = ST_ADD;
        end else begin
          win_waddr = wr_slot;
          alu_b     = ALU_W'(sample_r);
          sum_nxt   = $signed(alu_res[SUM_W-1:0]);
          count_nxt = count_r + CNT_W'(1);
          state_nxt = (count_r >= eff_len) ? ST_DROP : ST_MAG;
        end
      end

      ST_ADD: begin
        alu_a     = ALU_W'(sum_r);
        alu_b     = ALU_W'(sample_r);
        sum_nxt   = $signed(alu_res[SUM_W-1:0]);
        state_nxt = ST_MAG;
      end

      // Window longer than the set length: drop the oldest sample.
      ST_DROP: begin
        alu_a     = ALU_W'(sum_r);
        alu_b     = ALU_W'($signed(win_rd));
        alu_sub   = 1'b1;
        sum_nxt   = $signed(alu_res[SUM_W-1:0]);
        head_nxt  = head_inc;
        count_nxt = count_r - CNT_W'(1);
        state_nxt = ST_MAG;
      end

      // Load the magnitude of the sum as the dividend; an empty window gives an average of zero.
      ST_MAG: begin
        if (count_r == '0) begin
          avg_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          alu_b     = ALU_W'(sum_r);
          alu_sub   = 1'b1;
          dvd_nxt   = sum_r[SUM_W-1] ? alu_res[SUM_W-1:0] : sum_r;
          rem_nxt   = '0;
          bit_nxt   = BIT_W'(SUM_W - 1);
          state_nxt = ST_DIV;
        end
      end

      // One restoring divide step per cycle; quotient bits shift into the dividend.
      ST_DIV: begin
        alu_a   = ALU_W'(div_shift);
        alu_b   = ALU_W'(count_r);
        alu_sub = 1'b1;
        if (!alu_neg) begin
          rem_nxt = alu_res[CNT_W-1:0];
          dvd_nxt = {dvd_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = div_shift[CNT_W-1:0];
          dvd_nxt = {dvd_r[SUM_W-2:0], 1'b0};
        end
        if (bit_r == '0) begin
          state_nxt = ST_SIGN;
        end else begin
          bit_nxt = bit_r - BIT_W'(1);
        end
      end

      // Restore the sign; truncation toward zero follows from dividing magnitudes.
      ST_SIGN: begin
        alu_b     = ALU_W'(dvd_r);
        alu_sub   = 1'b1;
        avg_nxt   = sum_r[SUM_W-1] ? $signed(alu_res[7:0]) : $signed(dvd_r[7:0]);
        state_nxt = ST_FIN;
      end

      // Stop level first, then the bands in order; the first match wins.
      ST_CMP: begin
        alu_a   = ALU_W'(avg_r);
        alu_b   = ALU_W'(cmp_thr);
        alu_sub = 1'b1;
        unique case (cmp_r)
          CMP_STOP: begin
            if (alu_neg) begin
              verdict_nxt = raft_pkg::VERDICT_TOO_WEAK;
              state_nxt   = ST_FIN;
            end else begin
              cmp_nxt = CMP_EIGHTH;
            end
          end
          CMP_EIGHTH: begin
            if (alu_neg) begin
              period_nxt = raft_pkg::PERIOD_EIGHT;
              state_nxt  = ST_COUNT;
            end else begin
              cmp_nxt = CMP_SIXTH;
            end
          end
          CMP_SIXTH: begin
            if (alu_neg) begin
              period_nxt = raft_pkg::PERIOD_SIX;
              state_nxt  = ST_COUNT;
            end else begin
              cmp_nxt = CMP_QUARTER;
            end
          end
          CMP_QUARTER: begin
            if (alu_neg) begin
              period_nxt = raft_pkg::PERIOD_FOUR;
              state_nxt  = ST_COUNT;
            end else begin
              cmp_nxt = CMP_HALF;
            end
          end
          default: begin
            period_nxt = alu_neg ? raft_pkg::PERIOD_TWO : raft_pkg::PERIOD_ONE;
            state_nxt  = ST_COUNT;
          end
        endcase
      end

      // Advance the frame counter and apply the period and configured checks.
      ST_COUNT: begin
        ctr_nxt = ctr_inc;
        if (!raft_pkg::phase_hit(ctr_inc, period_r)) begin
          verdict_nxt = raft_pkg::VERDICT_SKIPPED;
        end else if (!configured_r) begin
          verdict_nxt = raft_pkg::VERDICT_UNCONFIG;
        end else begin
          verdict_nxt = raft_pkg::VERDICT_SENT;
          send_nxt    = 1'b1;
        end
        state_nxt = ST_FIN;
      end

      // Hand the result to the output register once it is free.
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          o_send_nxt    = send_r;
          o_verdict_nxt = verdict_r;
          o_avg_nxt     = avg_r;
          o_have_nxt    = (count_r != '0);
          o_period_nxt  = period_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, bookkeeping, configuration and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cmp_r        <= CMP_STOP;
      count_r      <= '0;
      head_r       <= '0;
      sum_r        <= '0;
      avg_r        <= '0;
      ctr_r        <= '0;
      out_valid_r  <= 1'b0;
      wlen_r       <= raft_pkg::RST_WINDOW_LENGTH;
      stop_r       <= raft_pkg::RST_STOP_LEVEL;
      eighth_r     <= raft_pkg::RST_BAND_EIGHTH;
      sixth_r      <= raft_pkg::RST_BAND_SIXTH;
      quarter_r    <= raft_pkg::RST_BAND_QUARTER;
      half_r       <= raft_pkg::RST_BAND_HALF;
      configured_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_r       <= cmp_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      sum_r       <= sum_nxt;
      avg_r       <= avg_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          raft_pkg::REG_WINDOW_LENGTH: wlen_r       <= cfg_data[3:0];
          raft_pkg::REG_STOP_LEVEL:    stop_r       <= $signed(cfg_data);
          raft_pkg::REG_BAND_EIGHTH:   eighth_r     <= $signed(cfg_data);
          raft_pkg::REG_BAND_SIXTH:    sixth_r      <= $signed(cfg_data);
          raft_pkg::REG_BAND_QUARTER:  quarter_r    <= $signed(cfg_data);
          raft_pkg::REG_BAND_HALF:     half_r       <= $signed(cfg_data);
          raft_pkg::REG_CONFIGURED:    configured_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    sample_r    <= sample_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    bit_r       <= bit_nxt;
    verdict_r   <= verdict_nxt;
    period_r    <= period_nxt;
    send_r      <= send_nxt;
    o_send_r    <= o_send_nxt;
    o_verdict_r <= o_verdict_nxt;
    o_avg_r     <= o_avg_nxt;
    o_have_r    <= o_have_nxt;
    o_period_r  <= o_period_nxt;
    if (win_we) begin
      win_r[win_waddr] <= sample_r;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, o_period_r, o_have_r, o_avg_r, o_verdict_r, o_send_r};

  // Checks on the window bookkeeping and the sequencer.
  `RAFT_ASSERT_ALWAYS(a_count_bound, int'(count_r) <= raft_pkg::MAX_WINDOW, "window count overflow")
  `RAFT_ASSERT_SAME(a_empty_sum, count_r == '0, sum_r == '0, "empty window with nonzero sum")
  `RAFT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready while busy")
  `RAFT_ASSERT_SAME(a_send_verdict, out_valid_r && o_send_r, o_verdict_r == raft_pkg::VERDICT_SENT, "send without sent verdict")

endmodule
